// ===== design/lcdc_pkg.sv =====
// Shared types and constants for the LED channel dimmer controller.
`default_nettype none

package lcdc_pkg;

    localparam int CHANNELS    = 6;
    localparam int MAX_RESULTS = 12;
    localparam int LVL_W       = 8;
    localparam int THR_W       = 12;
    localparam int VAL_W       = 16;
    localparam int FLD_W       = 3;

    localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PEND_W  = 2 * CHANNELS;
    localparam int POS_W   = $clog2(PEND_W);
    localparam int CNT_SPAN = (PEND_W > LVL_W) ? PEND_W : LVL_W;
    localparam int CNT_W   = $clog2(CNT_SPAN);
    localparam int DIVK_W  = $clog2(LVL_W);
    localparam int REM_W   = THR_W + LVL_W;
    localparam int EMIT_W  = $clog2(MAX_RESULTS);

    // floor(sum / CHANNELS) as (sum * RECIP) >> RECIP_SH, exact over the sum range
    localparam int SUM_W    = $clog2(CHANNELS * 255 + 1);
    localparam int RECIP_SH = SUM_W + $clog2(CHANNELS);
    localparam int RECIP    = ((2 ** RECIP_SH) + CHANNELS - 1) / CHANNELS;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int AVG_PW   = SUM_W + RECIP_W;

    localparam logic [THR_W-1:0] DARK_THR_RST = THR_W'(500);
    localparam logic [LVL_W-1:0] MAX_BRT_RST  = LVL_W'(255);

    localparam logic [FLD_W-1:0] MODE_SET    = 3'd0;
    localparam logic [FLD_W-1:0] MODE_ON     = 3'd1;
    localparam logic [FLD_W-1:0] MODE_OFF    = 3'd2;
    localparam logic [FLD_W-1:0] MODE_TOGGLE = 3'd3;
    localparam logic [FLD_W-1:0] MODE_AUTO   = 3'd4;
    localparam logic [FLD_W-1:0] MODE_QUERY  = 3'd5;

    localparam logic [FLD_W-1:0] TARGET_ALL = 3'd6;

    localparam logic CFG_DARK_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_BRIGHTNESS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_SUM,
        S_AVG,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             div;
        logic             apply;
        logic             sum;
        logic             avg;
        logic             emit;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic pend_none;
        logic cur_set;
        logic final_word;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/led_channel_dimmer_controller_unit.sv =====
// Top level of the six-channel LED dimmer controller.
//
// Commands enter on the s_axis word channel (mode in tuser; target and
// value in tdata). Each command yields one or more result words on
// m_axis, one per duty write in write order, tlast on the final one; a
// command that writes nothing yields a single word with tuser low.
// Every word of a command carries the target's on flag and level after
// the command; for all channels, any-on and the floor average level.
// One command is processed at a time: tready is high only while idle.
// A command passes through accept, multiply, 8 divide steps (one
// quotient bit each), apply, a summing step per channel, average, then
// at most 12 emission positions (one word when nothing is written).
// Result words sit in an output register; when m_axis_tready is low the
// emission walk holds on the next word and resumes without loss.
// Reset (synchronous, active low) turns all channels off with level 0
// and loads dark_threshold 500 and max_brightness 255. The config port
// writes register i_cfg_addr at any edge with i_cfg_wr_en high.
`default_nettype none

module led_channel_dimmer_controller_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // target[2:0], value[18:3], zero pad
    input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // channel[2:0], duty[10:3], target_on[11],
                                            // target_level[19:12], zero pad
    output logic [0:0]       m_axis_tuser,  // write_valid[0]
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [11:0] i_cfg_wdata
);
    import lcdc_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic             wv;
    logic [FLD_W-1:0] channel;
    logic [LVL_W-1:0] duty;
    logic             target_on;
    logic [LVL_W-1:0] target_level;

    lcdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lcdc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (s_axis_tuser),
        .i_target       (s_axis_tdata[2:0]),
        .i_value        (s_axis_tdata[18:3]),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_write_valid  (wv),
        .o_channel      (channel),
        .o_duty         (duty),
        .o_target_on    (target_on),
        .o_target_level (target_level),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, target_level, target_on, duty, channel};
    assign m_axis_tuser = wv;

endmodule

`default_nettype wire

// ===== design/lcdc_ctrl.sv =====
// Command sequencer of the LED channel dimmer controller.
`default_nettype none

module lcdc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lcdc_pkg::t_stat i_stat,
    output lcdc_pkg::t_cmd     o_cmd
);
    import lcdc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(LVL_W - 1)) begin
                    n_state = S_APPLY;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPLY: begin
                n_state = S_SUM;
                n_cnt   = '0;
            end
            S_SUM: begin
                if (r_cnt == CNT_W'(CHANNELS - 1)) begin
                    n_state = S_AVG;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_AVG: begin
                n_state = S_EMIT;
                n_cnt   = '0;
            end
            S_EMIT: begin
                // skip empty positions, wait for the output slot on set ones
                if (i_stat.pend_none) begin
                    if (i_stat.slot_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_stat.cur_set) begin
                    if (i_stat.slot_free) begin
                        if (i_stat.final_word) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.cnt  = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL:   o_cmd.mul   = 1'b1;
            S_DIV:   o_cmd.div   = 1'b1;
            S_APPLY: o_cmd.apply = 1'b1;
            S_SUM:   o_cmd.sum   = 1'b1;
            S_AVG:   o_cmd.avg   = 1'b1;
            S_EMIT: begin
                o_cmd.emit = i_stat.slot_free && (i_stat.pend_none || i_stat.cur_set);
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lcdc_dpath.sv =====
// Datapath: channel state, auto level divider, status sum and result register.
`default_nettype none

module lcdc_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lcdc_pkg::t_cmd             i_cmd,
    output lcdc_pkg::t_stat                 o_stat,
    input  wire logic [lcdc_pkg::FLD_W-1:0] i_mode,
    input  wire logic [lcdc_pkg::FLD_W-1:0] i_target,
    input  wire logic signed [lcdc_pkg::VAL_W-1:0] i_value,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_addr,
    input  wire logic [lcdc_pkg::THR_W-1:0] i_cfg_wdata,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_write_valid,
    output logic [lcdc_pkg::FLD_W-1:0]      o_channel,
    output logic [lcdc_pkg::LVL_W-1:0]      o_duty,
    output logic                            o_target_on,
    output logic [lcdc_pkg::LVL_W-1:0]      o_target_level,
    output logic                            o_last
);
    import lcdc_pkg::*;

    logic [FLD_W-1:0]        r_mode;
    logic [FLD_W-1:0]        r_target;
    logic signed [VAL_W-1:0] r_value;
    logic [THR_W-1:0]        r_thr;
    logic [LVL_W-1:0]        r_max;
    logic [LVL_W-1:0]        r_level [CHANNELS];
    logic [CHANNELS-1:0]     r_on;
    logic [REM_W-1:0]        r_rem;
    logic [LVL_W-1:0]        r_q;
    logic [PEND_W-1:0]       r_pend;
    logic                    r_za, r_zb;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_st_on;
    logic [LVL_W-1:0]        r_st_lvl;
    logic [EMIT_W-1:0]       r_nemit;
    logic                    r_out_valid;
    logic                    r_wv;
    logic [FLD_W-1:0]        r_ch;
    logic [LVL_W-1:0]        r_duty;
    logic                    r_ton;
    logic [LVL_W-1:0]        r_tlvl;
    logic                    r_last;

    logic                    is_all, is_ch, any_old, tgt_on;
    logic [CHANNELS-1:0]     hit;
    logic [LVL_W-1:0]        clamp_lvl, auto_lvl, lvl;
    logic [LVL_W-1:0]        n_level [CHANNELS];
    logic [CHANNELS-1:0]     n_on, mask_a, mask_b;
    logic                    za, zb;
    logic [POS_W-1:0]        pos, pos_ch;
    logic                    pass_b;
    logic [CH_IW-1:0]        ch_idx;
    logic [CH_IW+FLD_W-1:0]  ch_ext;
    logic [DIVK_W-1:0]       div_k;
    logic [REM_W-1:0]        thr_sh;
    logic [PEND_W-1:0]       pend_after;
    logic                    final_word;
    logic [AVG_PW-1:0]       avg_prod, avg_sh;
    logic [LVL_W-1:0]        rd_level;
    logic                    emit_zero;

    assign is_all  = (r_target == TARGET_ALL);
    assign is_ch   = !is_all && (32'(r_target) < CHANNELS);
    assign any_old = |r_on;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            hit[i] = is_all || (is_ch && (32'(r_target) == i));
        end
    end

    assign tgt_on = |(r_on & hit);

    // clamp a signed request to 0..255
    assign clamp_lvl = r_value[VAL_W-1] ? '0 :
                       (|r_value[VAL_W-2:LVL_W]) ? '1 : r_value[LVL_W-1:0];

    always_comb begin
        if (r_value[VAL_W-1]) begin
            auto_lvl = r_max;
        end else if ($unsigned(r_value) < VAL_W'(r_thr)) begin
            auto_lvl = r_max - r_q;
        end else begin
            auto_lvl = '0;
        end
    end

    assign lvl = (r_mode == MODE_AUTO) ? auto_lvl : clamp_lvl;

    // new channel state and the write plan: pass A, then pass B for auto
    always_comb begin
        mask_a = '0;
        mask_b = '0;
        za     = 1'b0;
        zb     = 1'b0;
        n_on   = r_on;
        for (int i = 0; i < CHANNELS; i++) begin
            n_level[i] = r_level[i];
        end
        unique case (r_mode)
            MODE_SET: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (hit[i]) begin
                        n_level[i] = lvl;
                    end
                end
                mask_a = hit & r_on;
            end
            MODE_ON: begin
                n_on   = r_on | hit;
                mask_a = hit;
            end
            MODE_OFF: begin
                n_on   = r_on & ~hit;
                mask_a = hit;
                za     = 1'b1;
            end
            MODE_TOGGLE: begin
                n_on   = tgt_on ? (r_on & ~hit) : (r_on | hit);
                mask_a = hit;
                za     = tgt_on;
            end
            MODE_AUTO: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_level[i] = lvl;
                end
                mask_a = r_on;
                if ((lvl != '0) && !any_old) begin
                    n_on   = '1;
                    mask_b = '1;
                end else if ((lvl == '0) && any_old) begin
                    n_on   = '0;
                    mask_b = '1;
                    zb     = 1'b1;
                end
            end
            default: begin
                mask_a = '0;
            end
        endcase
    end

    // position walk: first CHANNELS positions are pass A, the rest pass B
    assign pos    = i_cmd.cnt[POS_W-1:0];
    assign pass_b = (32'(pos) >= CHANNELS);
    assign pos_ch = pass_b ? (pos - POS_W'(CHANNELS)) : pos;
    assign ch_idx = pos_ch[CH_IW-1:0];
    assign ch_ext = (CH_IW + FLD_W)'(ch_idx);
    assign rd_level = r_level[ch_idx];
    assign emit_zero = pass_b ? r_zb : r_za;

    assign div_k  = DIVK_W'(LVL_W - 1) - i_cmd.cnt[DIVK_W-1:0];
    assign thr_sh = REM_W'(r_thr) << div_k;

    assign pend_after = r_pend & ~(PEND_W'(1) << pos);
    assign final_word = (pend_after == '0) || (r_nemit == EMIT_W'(MAX_RESULTS - 1));

    assign avg_prod = AVG_PW'(r_sum) * AVG_PW'(RECIP);
    assign avg_sh   = avg_prod >> RECIP_SH;

    assign o_stat.slot_free  = !r_out_valid || i_out_ready;
    assign o_stat.pend_none  = (r_pend == '0);
    assign o_stat.cur_set    = r_pend[pos];
    assign o_stat.final_word = final_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= DARK_THR_RST;
            r_max       <= MAX_BRT_RST;
            r_on        <= '0;
            r_pend      <= '0;
            r_nemit     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_level[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_DARK_THRESHOLD: r_thr <= i_cfg_wdata;
                    CFG_MAX_BRIGHTNESS: r_max <= i_cfg_wdata[LVL_W-1:0];
                    default:            r_thr <= r_thr;
                endcase
            end
            if (i_cmd.apply) begin
                r_on    <= n_on;
                r_pend  <= {mask_b, mask_a};
                r_nemit <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_level[i] <= n_level[i];
                end
            end
            if (i_cmd.emit) begin
                r_pend      <= pend_after;
                r_nemit     <= r_nemit + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_target <= i_target;
            r_value  <= i_value;
        end
        if (i_cmd.mul) begin
            // product only matters when the reading is below the threshold
            r_rem <= REM_W'(r_value[THR_W-1:0]) * REM_W'(r_max);
            r_q   <= '0;
        end
        if (i_cmd.div) begin
            if (r_rem >= thr_sh) begin
                r_rem       <= r_rem - thr_sh;
                r_q[div_k]  <= 1'b1;
            end
        end
        if (i_cmd.apply) begin
            r_za     <= za;
            r_zb     <= zb;
            r_sum    <= '0;
            r_st_on  <= 1'b0;
            r_st_lvl <= '0;
        end
        if (i_cmd.sum) begin
            r_sum <= r_sum + SUM_W'(rd_level);
            if (is_ch && (32'(r_target) == 32'(pos))) begin
                r_st_on  <= r_on[ch_idx];
                r_st_lvl <= rd_level;
            end
        end
        if (i_cmd.avg && is_all) begin
            r_st_on  <= |r_on;
            r_st_lvl <= avg_sh[LVL_W-1:0];
        end
        if (i_cmd.emit) begin
            // hold the status with the word so the next command cannot disturb it
            r_ton  <= r_st_on;
            r_tlvl <= r_st_lvl;
            if (r_pend == '0) begin
                r_wv   <= 1'b0;
                r_ch   <= '0;
                r_duty <= '0;
                r_last <= 1'b1;
            end else begin
                r_wv   <= 1'b1;
                r_ch   <= ch_ext[FLD_W-1:0];
                r_duty <= emit_zero ? '0 : rd_level;
                r_last <= final_word;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_valid  = r_wv;
    assign o_channel      = r_ch;
    assign o_duty         = r_duty;
    assign o_target_on    = r_ton;
    assign o_target_level = r_tlvl;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== tb/led_channel_dimmer_controller_unit_tb.sv =====
// Self-checking testbench for the LED channel dimmer controller top level.
`timescale 1ns / 1ps

module led_channel_dimmer_controller_unit_tb;

    import lcdc_pkg::*;

    localparam logic [FLD_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [FLD_W-1:0] MODE_SPARE7 = 3'd7;
    localparam logic [FLD_W-1:0] TARGET_NONE = 3'd7;
    localparam int DIR_N         = 25;
    localparam int PHASES        = 6;
    localparam int ITEMS_PER_PH  = 58;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic             wv;
        logic [2:0]       ch;
        logic [LVL_W-1:0] duty;
        logic             ton;
        logic [LVL_W-1:0] tlvl;
        logic             last;
    } dim_word_t;

    typedef struct packed {
        logic [FLD_W-1:0] mode;
        logic [FLD_W-1:0] tgt;
        logic [VAL_W-1:0] val;
        logic             fixed;
        dim_word_t        word;
    } dim_cmd_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_wr_en;
    logic        i_cfg_addr;
    logic [11:0] i_cfg_wdata;

    // Model of the channel bank
    logic [LVL_W-1:0] level_q [CHANNELS];
    logic             lit_q   [CHANNELS];
    logic [THR_W-1:0] thr_q;
    logic [LVL_W-1:0] maxb_q;
    logic [2:0]       wr_ch   [MAX_RESULTS];
    logic [LVL_W-1:0] wr_duty [MAX_RESULTS];
    int               wr_n;

    dim_word_t duty_exp_q [$];
    dim_cmd_t  sent_cmd_q [$];
    dim_cmd_t  dir_tab [DIR_N];
    int        errors;
    int        cycle_cnt;
    int        cmds_accepted;
    int        cur_thr;

    led_channel_dimmer_controller_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void push_duty(input int ch, input logic [LVL_W-1:0] duty);
        if (wr_n < MAX_RESULTS) begin
            wr_ch[wr_n]   = ch[2:0];
            wr_duty[wr_n] = duty;
            wr_n++;
        end
    endfunction

    function automatic logic any_lit();
        logic r;
        r = 1'b0;
        for (int i = 0; i < CHANNELS; i++) r |= lit_q[i];
        return r;
    endfunction

    function automatic void light_all();
        for (int i = 0; i < CHANNELS; i++) begin
            lit_q[i] = 1'b1;
            push_duty(i, level_q[i]);
        end
    endfunction

    function automatic void dark_all();
        for (int i = 0; i < CHANNELS; i++) begin
            lit_q[i] = 1'b0;
            push_duty(i, '0);
        end
    endfunction

    function automatic void level_all(input logic [LVL_W-1:0] lvl);
        for (int i = 0; i < CHANNELS; i++) begin
            level_q[i] = lvl;
            if (lit_q[i]) push_duty(i, lvl);
        end
    endfunction

    // Apply one command to the model and queue the duty words it causes.
    function automatic void predict_duty_words(input logic [FLD_W-1:0] mode,
                                               input logic [FLD_W-1:0] tgt,
                                               input logic [VAL_W-1:0] raw,
                                               input logic             push_words);
        int               val;
        int unsigned      sum;
        logic             is_all;
        logic             is_ch;
        logic [LVL_W-1:0] lvl;
        logic             st_on;
        logic [LVL_W-1:0] st_lvl;
        dim_word_t        w;
        val    = $signed(raw);
        is_all = (tgt == TARGET_ALL);
        is_ch  = !is_all && (int'(tgt) < CHANNELS);
        wr_n   = 0;
        st_on  = 1'b0;
        st_lvl = '0;
        case (mode)
            MODE_SET: begin
                lvl = (val < 0) ? 8'd0 : (val > 255) ? 8'd255 : val[7:0];
                if (is_all) begin
                    level_all(lvl);
                end else if (is_ch) begin
                    level_q[tgt] = lvl;
                    if (lit_q[tgt]) push_duty(tgt, lvl);
                end
            end
            MODE_ON: begin
                if (is_all) begin
                    light_all();
                end else if (is_ch) begin
                    lit_q[tgt] = 1'b1;
                    push_duty(tgt, level_q[tgt]);
                end
            end
            MODE_OFF: begin
                if (is_all) begin
                    dark_all();
                end else if (is_ch) begin
                    lit_q[tgt] = 1'b0;
                    push_duty(tgt, '0);
                end
            end
            MODE_TOGGLE: begin
                if (is_all) begin
                    if (any_lit()) dark_all();
                    else light_all();
                end else if (is_ch) begin
                    lit_q[tgt] = !lit_q[tgt];
                    push_duty(tgt, lit_q[tgt] ? level_q[tgt] : 8'd0);
                end
            end
            MODE_AUTO: begin
                if (val < 0) lvl = maxb_q;
                else if (val < int'(thr_q))
                    lvl = maxb_q - LVL_W'((val * int'(maxb_q)) / int'(thr_q));
                else lvl = '0;
                level_all(lvl);
                if (lvl != 0 && !any_lit()) light_all();
                else if (lvl == 0 && any_lit()) dark_all();
            end
            default: ;
        endcase
        if (is_all) begin
            sum = 0;
            for (int i = 0; i < CHANNELS; i++) sum += level_q[i];
            st_on  = any_lit();
            st_lvl = LVL_W'(sum / CHANNELS);
        end else if (is_ch) begin
            st_on  = lit_q[tgt];
            st_lvl = level_q[tgt];
        end
        if (!push_words) return;
        if (wr_n == 0) begin
            w = '{1'b0, 3'd0, 8'd0, st_on, st_lvl, 1'b1};
            duty_exp_q.push_back(w);
        end
        for (int k = 0; k < wr_n; k++) begin
            w = '{1'b1, wr_ch[k], wr_duty[k], st_on, st_lvl, k == wr_n - 1};
            duty_exp_q.push_back(w);
        end
    endfunction

    function automatic dim_cmd_t plain(input logic [FLD_W-1:0] mode,
                                       input logic [FLD_W-1:0] tgt,
                                       input logic [VAL_W-1:0] val);
        dim_cmd_t c;
        c = '0;
        c.mode = mode;
        c.tgt  = tgt;
        c.val  = val;
        return c;
    endfunction

    // Row with a single, hand-written expected word.
    function automatic dim_cmd_t fixed_row(input logic [FLD_W-1:0] mode,
                                           input logic [FLD_W-1:0] tgt,
                                           input logic [VAL_W-1:0] val,
                                           input logic wv, input logic [2:0] ch,
                                           input logic [7:0] duty, input logic ton,
                                           input logic [7:0] tlvl);
        dim_cmd_t c;
        c = plain(mode, tgt, val);
        c.fixed = 1'b1;
        c.word  = '{wv, ch, duty, ton, tlvl, 1'b1};
        return c;
    endfunction

    function automatic dim_cmd_t random_cmd(input int thr);
        dim_cmd_t c;
        int       r;
        c = '0;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            c.mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
        end else begin
            r = $urandom_range(0, 9);
            c.mode = (r < 3) ? MODE_SET : (r == 3) ? MODE_ON : (r == 4) ? MODE_OFF :
                     (r < 7) ? MODE_TOGGLE : (r < 9) ? MODE_AUTO : MODE_QUERY;
        end
        r = $urandom_range(0, 9);
        c.tgt = (r < 6) ? FLD_W'($urandom_range(0, CHANNELS - 1)) :
                (r < 9) ? TARGET_ALL : TARGET_NONE;
        r = $urandom_range(0, 9);
        if (c.mode == MODE_SET) begin
            if (r < 6) c.val = VAL_W'($urandom_range(0, 255));
            else if (r == 6) c.val = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else c.val = VAL_W'($urandom);
        end else if (c.mode == MODE_AUTO) begin
            if (r < 4 && thr > 0) c.val = VAL_W'($urandom_range(0, thr - 1));
            else if (r < 6) c.val = VAL_W'(thr - 2 + int'($urandom_range(0, 3)));
            else if (r < 8) c.val = 16'h8000 | VAL_W'($urandom);
            else c.val = VAL_W'($urandom);
        end else begin
            c.val = VAL_W'($urandom);
        end
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Predict on each accepted command, check each accepted word.
    always @(posedge i_clk) begin : monitor
        dim_cmd_t  c;
        dim_word_t e;
        cycle_cnt++;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                level_q[i] = '0;
                lit_q[i]   = 1'b0;
            end
            thr_q  = DARK_THR_RST;
            maxb_q = MAX_BRT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_DARK_THRESHOLD: thr_q  = i_cfg_wdata;
                    CFG_MAX_BRIGHTNESS: maxb_q = i_cfg_wdata[LVL_W-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                c = sent_cmd_q.pop_front();
                cmds_accepted++;
                predict_duty_words(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3],
                                   !c.fixed);
                if (c.fixed) duty_exp_q.push_back(c.word);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (duty_exp_q.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_CAP)
                        $display("%0t: word with nothing expected: expected none, got %h/%b",
                                 $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    e = duty_exp_q.pop_front();
                    check_field("write_valid", e.wv, m_axis_tuser[0]);
                    check_field("channel", e.ch, m_axis_tdata[2:0]);
                    check_field("duty", e.duty, m_axis_tdata[10:3]);
                    check_field("target_on", e.ton, m_axis_tdata[11]);
                    check_field("target_level", e.tlvl, m_axis_tdata[19:12]);
                    check_field("last", e.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: segments of free flow, random stalls and a periodic pattern,
    // plus one long hold-off so the block backs up onto its input.
    initial begin : receiver
        int  kind;
        int  seg;
        int  held;
        int  phase;
        logic hold_done;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        phase = 0;
        forever begin
            if (!hold_done && cmds_accepted >= 90) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < 400) begin
                    @(negedge i_clk);
                    held++;
                end
            end
            kind = $urandom_range(0, 3);
            seg  = $urandom_range(10, 60);
            repeat (seg) begin
                @(negedge i_clk);
                phase++;
                case (kind)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= (phase % 5) > 1;
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_cmd(input dim_cmd_t c, input int gap);
        sent_cmd_q.push_back(c);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.val, c.tgt};
        s_axis_tuser  <= c.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait for every outstanding word to drain.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (duty_exp_q.size() != 0 || sent_cmd_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [11:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int thr_set  [PHASES];
        int maxb_set [PHASES];
        int left;
        int blen;
        int gap;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_DARK_THRESHOLD;
        i_cfg_wdata   = '0;
        errors        = 0;
        cycle_cnt     = 0;
        cmds_accepted = 0;
        cur_thr       = DARK_THR_RST;

        thr_set  = '{int'(DARK_THR_RST), 4095, 1, 0, 777, int'($urandom_range(1, 4095))};
        maxb_set = '{int'(MAX_BRT_RST), 255, 0, 128, 1, int'($urandom_range(0, 255))};

        dir_tab = '{
            fixed_row(MODE_QUERY,  3'd0,        16'd0,    1'b0, 3'd0, 8'd0,   1'b0, 8'd0),
            fixed_row(MODE_QUERY,  TARGET_ALL,  16'd0,    1'b0, 3'd0, 8'd0,   1'b0, 8'd0),
            fixed_row(MODE_SET,    3'd0,        16'h7FFF, 1'b0, 3'd0, 8'd0,   1'b0, 8'd255),
            fixed_row(MODE_SET,    3'd1,        16'h8000, 1'b0, 3'd0, 8'd0,   1'b0, 8'd0),
            fixed_row(MODE_SET,    TARGET_NONE, 16'd100,  1'b0, 3'd0, 8'd0,   1'b0, 8'd0),
            fixed_row(MODE_ON,     3'd0,        16'd0,    1'b1, 3'd0, 8'd255, 1'b1, 8'd255),
            plain(MODE_SET,    3'd0,        16'd128),
            plain(MODE_TOGGLE, 3'd0,        16'hFFFF),
            plain(MODE_TOGGLE, 3'd0,        16'h5555),
            fixed_row(MODE_OFF,    TARGET_NONE, 16'hAAAA, 1'b0, 3'd0, 8'd0,   1'b0, 8'd0),
            plain(MODE_SPARE6, 3'd0,        16'h1234),
            plain(MODE_SPARE7, TARGET_ALL,  16'hEDCB),
            plain(MODE_SET,    TARGET_ALL,  16'd300),
            plain(MODE_ON,     TARGET_ALL,  16'd0),
            plain(MODE_TOGGLE, TARGET_ALL,  16'd0),
            plain(MODE_TOGGLE, TARGET_ALL,  16'd0),
            plain(MODE_AUTO,   3'd5,        16'h8000),
            plain(MODE_AUTO,   TARGET_NONE, 16'd0),
            plain(MODE_AUTO,   3'd2,        16'd499),
            plain(MODE_AUTO,   TARGET_ALL,  16'd500),
            plain(MODE_AUTO,   3'd0,        16'd250),
            plain(MODE_OFF,    TARGET_ALL,  16'd0),
            plain(MODE_AUTO,   3'd4,        16'h7FFF),
            plain(MODE_ON,     3'd5,        16'd0),
            plain(MODE_QUERY,  3'd5,        16'hFFFF)
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) send_cmd(dir_tab[i], $urandom_range(0, 3));

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_reg(CFG_DARK_THRESHOLD, 12'(thr_set[p]));
                write_reg(CFG_MAX_BRIGHTNESS, 12'(maxb_set[p]));
                cur_thr = thr_set[p];
            end
            left = ITEMS_PER_PH;
            while (left > 0) begin
                blen = $urandom_range(1, 10);
                for (int j = 0; j < blen && left > 0; j++) begin
                    gap = (j == blen - 1) ? $urandom_range(1, 15) : 0;
                    send_cmd(random_cmd(cur_thr), gap);
                    left--;
                end
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && duty_exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcdc_pkg.sv
design/lcdc_ctrl.sv
design/lcdc_dpath.sv
design/led_channel_dimmer_controller_unit.sv
tb/led_channel_dimmer_controller_unit_tb.sv
